[rtl/core/rgbgd_pkg.sv]
// Package for the RGB to gray 2x2 downscaler: frame geometry, widths,
// pixel, result and command types, and the gray conversion function.
// No dependencies.
package rgbgd_pkg;

  localparam int IMAGE_WIDTH  = 32;
  localparam int IMAGE_HEIGHT = 8;

  localparam int PAIR_COUNT = IMAGE_WIDTH / 2;
  localparam int COL_W      = (IMAGE_WIDTH > 2) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int ROW_W      = (IMAGE_HEIGHT > 2) ? $clog2(IMAGE_HEIGHT) : 1;
  localparam int IDX_W      = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  localparam logic [COL_W-1:0] LAST_COL      = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [COL_W-1:0] LAST_PAIR_COL = COL_W'((IMAGE_WIDTH / 2) * 2 - 1);
  localparam logic [ROW_W-1:0] LAST_PAIR_ROW = ROW_W'((IMAGE_HEIGHT / 2) * 2 - 1);

  localparam int GRAY_W = 8;
  localparam int PAIR_W = 9;
  localparam int SUM_W  = 10;

  // Depths of the two queues; both must be powers of two.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = (CMDQ_DEPTH > 2) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = (OUTQ_DEPTH > 2) ? $clog2(OUTQ_DEPTH) : 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] gray_avg;
    logic       frame_last;
  } result_t;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } cmd_t;

  function automatic logic [GRAY_W-1:0] to_gray(input pixel_t p);
    logic [11:0] t;
    t = {2'b00, p.red, 2'b00} + {4'b0000, p.red}
      + {1'b0, p.green, 3'b000} + {4'b0000, p.green}
      + {3'b000, p.blue, 1'b0};
    return t[11:4];
  endfunction

endpackage

[rtl/core/rgbgd_front.sv]
// Front part: converts pixels to gray, tracks column and row, pairs grays
// and issues store or emit commands. Depends on rgbgd_pkg.
module rgbgd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  rgbgd_pkg::pixel_t   pixel_i,
  input  logic                cmdq_full_i,
  output logic                full,
  output logic                cmd_push_o,
  output rgbgd_pkg::cmd_t     cmd_o
);
  import rgbgd_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [GRAY_W-1:0] left_gray_q, left_gray_d;
  logic [GRAY_W-1:0] gray;
  logic              accept;

  assign full   = cmdq_full_i;
  assign accept = push && !cmdq_full_i;
  assign gray   = to_gray(pixel_i);

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_gray_d = left_gray_q;
    if (accept) begin
      if (!col_q[0]) begin
        left_gray_d = gray;
      end
      if (col_q == LAST_COL) begin
        col_d = '0;
        row_d = (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    cmd_push_o = accept && col_q[0];
    cmd_o.op   = row_q[0] ? OP_EMIT : OP_STORE;
    cmd_o.idx  = IDX_W'(col_q >> 1);
    cmd_o.pair = {1'b0, left_gray_q} + {1'b0, gray};
    cmd_o.last = (row_q == LAST_PAIR_ROW) && (col_q == LAST_PAIR_COL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_gray_q <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      left_gray_q <= left_gray_d;
    end
  end

endmodule

[rtl/core/rgbgd_cmd_queue.sv]
// Command queue between front and back parts: a small register FIFO.
// Depends on rgbgd_pkg.
module rgbgd_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rgbgd_pkg::cmd_t  cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rgbgd_pkg::cmd_t  cmd_o
);
  import rgbgd_pkg::*;

  cmd_t               entry_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, rptr_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (CMDQ_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (CMDQ_AW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
    else $error("command queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + (CMDQ_AW + 1)'(1)))
    else $error("command queue lost a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> ((wptr_q - rptr_q) == cnt_q[CMDQ_AW-1:0]))
    else $error("command queue pointers disagree with count");

endmodule

[rtl/core/rgbgd_back.sv]
// Back part: line store of pair sums, emit stage and result queue.
// Depends on rgbgd_pkg.
module rgbgd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  rgbgd_pkg::cmd_t    cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output rgbgd_pkg::result_t result_o
);
  import rgbgd_pkg::*;

  logic [PAIR_W-1:0]  line_q [PAIR_COUNT];
  logic [PAIR_W-1:0]  rd_q;
  logic [PAIR_W-1:0]  s1_pair_q;
  logic               s1_last_q;
  logic               s1_valid_q;
  logic               s1_adv;
  logic               take_emit;
  logic [SUM_W-1:0]   sum;
  result_t            oq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] owptr_q, orptr_q;
  logic [OUTQ_AW:0]   ocnt_q;
  logic               oq_full, oq_pop;

  assign oq_full   = (ocnt_q == (OUTQ_AW + 1)'(OUTQ_DEPTH));
  assign empty     = (ocnt_q == '0);
  assign result_o  = oq_q[orptr_q];
  assign oq_pop    = pop && !empty;
  assign s1_adv    = s1_valid_q && !oq_full;
  assign cmd_pop_o = cmd_valid_i && ((cmd_i.op == OP_STORE) || !s1_valid_q || s1_adv);
  assign take_emit = cmd_pop_o && (cmd_i.op == OP_EMIT);
  assign sum       = {1'b0, rd_q} + {1'b0, s1_pair_q};

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && (cmd_i.op == OP_STORE)) begin
      line_q[cmd_i.idx] <= cmd_i.pair;
    end
    if (take_emit) begin
      rd_q      <= line_q[cmd_i.idx];
      s1_pair_q <= cmd_i.pair;
      s1_last_q <= cmd_i.last;
    end
    if (s1_adv) begin
      oq_q[owptr_q] <= '{gray_avg: sum[SUM_W-1:2], frame_last: s1_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      owptr_q    <= '0;
      orptr_q    <= '0;
      ocnt_q     <= '0;
    end else begin
      if (take_emit) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        owptr_q <= owptr_q + OUTQ_AW'(1);
      end
      if (oq_pop) begin
        orptr_q <= orptr_q + OUTQ_AW'(1);
      end
      if (s1_adv && !oq_pop) begin
        ocnt_q <= ocnt_q + (OUTQ_AW + 1)'(1);
      end else if (oq_pop && !s1_adv) begin
        ocnt_q <= ocnt_q - (OUTQ_AW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("result queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(take_emit))
    else $error("emit stage loaded without an emit command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_pair_q) && $stable(rd_q)))
    else $error("stalled emit stage changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command popped from an empty queue");

endmodule

[rtl/core/rgb_gray_downscale_2x2_unit.sv]
// Takes one RGB pixel per clock while full is low, in raster order (32 x 8
// frame), and gives one gray value per 2x2 block, the mean of the four grays
// (5R+9G+2B)>>4, with frame_last set on the last block of each frame. A
// result reaches the output queue by way of the command queue and then the
// emit stage that reads the line store, whose sum is written into the result
// queue. The block sustains one pixel per clock while results are popped; the
// command queue and the two-entry result queue absorb short pop stalls, and
// full rises once both queues back up. No clearing pass after reset.
// Depends on rgbgd_pkg, rgbgd_front, rgbgd_cmd_queue and rgbgd_back.
module rgb_gray_downscale_2x2_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  rgbgd_pkg::pixel_t  pixel_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rgbgd_pkg::result_t result_o
);
  import rgbgd_pkg::*;

  logic cmd_push, cmdq_full, cmdq_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  rgbgd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .pixel_i     (pixel_i),
    .cmdq_full_i (cmdq_full),
    .full        (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  rgbgd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .valid_o (cmdq_valid),
    .cmd_o   (cmd_out)
  );

  rgbgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmdq_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

[tb/rgb_gray_downscale_2x2_unit_tb.sv]
// Self-checking testbench for rgb_gray_downscale_2x2_unit: streams RGB frames
// through push/full and checks each 2x2 gray average taken off empty/pop.
// Depends on rgbgd_pkg and the rgb_gray_downscale_2x2_unit RTL.
module rgb_gray_downscale_2x2_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbgd_pkg::*;

  localparam time CLK_PERIOD   = 8ns;
  localparam int  RESET_CYCLES = 12;
  localparam int  RANDOM_PIXELS = 1000;
  localparam int  IDLE_PCT     = 17;
  localparam int  DRAIN_AT     = 500;
  localparam int  SEND_QUIET_LO = 700;
  localparam int  SEND_QUIET_HI = 850;
  localparam int  HOLD_AT      = 80;
  localparam int  HOLD_CYCLES  = 120;
  localparam int  RECV_QUIET_LO = 150;
  localparam int  RECV_QUIET_HI = 190;
  localparam int  SETTLE_CYCLES = 10;
  localparam int  LIMIT_CYCLES = 200000;
  localparam int  LAST_PAIR_X  = (IMAGE_WIDTH / 2) * 2 - 1;
  localparam int  LAST_PAIR_Y  = (IMAGE_HEIGHT / 2) * 2 - 1;

  localparam logic [23:0] DIRECTED [24] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h010101, 24'hFEFEFE, 24'h800000, 24'h008000,
    24'h000080, 24'h7F7F7F, 24'h808080, 24'hAA55AA, 24'h55AA55, 24'h0F0F0F,
    24'hF0F0F0, 24'h123456, 24'hFEDCBA, 24'h01FF01, 24'hFF01FF, 24'h7FFF80
  };

  logic    clk_i   = 1'b0;
  logic    rst_ni  = 1'b0;
  logic    push    = 1'b0;
  pixel_t  pixel_i = '0;
  logic    pop     = 1'b0;
  logic    full;
  logic    empty;
  result_t result_o;

  pixel_t  pixel_backlog[$];
  result_t expected_averages[$];

  logic [PAIR_W-1:0] pair_line [PAIR_COUNT];
  logic [7:0]        left_gray;
  int                col_pos;
  int                row_pos;

  int total_pixels;
  int accepted_count;
  int received_count;
  int frame_ends;
  int full_stalls;
  int fail_count;
  int hold_left;
  bit held_off;

  rgb_gray_downscale_2x2_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .pixel_i  (pixel_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic predict_block_average(input pixel_t px);
    int      gray;
    int      pair;
    int      sum;
    result_t avg;
    gray = (5 * int'(px.red) + 9 * int'(px.green) + 2 * int'(px.blue)) >> 4;
    if ((col_pos % 2) == 0) begin
      left_gray = gray[7:0];
    end else begin
      pair = int'(left_gray) + gray;
      if ((row_pos % 2) == 0) begin
        pair_line[col_pos / 2] = pair[PAIR_W-1:0];
      end else begin
        sum = int'(pair_line[col_pos / 2]) + pair;
        avg.gray_avg   = sum[9:2];
        avg.frame_last = (row_pos == LAST_PAIR_Y) && (col_pos == LAST_PAIR_X);
        expected_averages.push_back(avg);
      end
    end
    col_pos++;
    if (col_pos >= IMAGE_WIDTH) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= IMAGE_HEIGHT) row_pos = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      pixel_i <= '0;
    end else begin
      if (push && !full) begin
        predict_block_average(pixel_i);
        void'(pixel_backlog.pop_front());
        accepted_count++;
      end
      if (push && full) begin
        full_stalls++;
      end else if (pixel_backlog.size() == 0) begin
        push <= 1'b0;
      end else if (accepted_count == DRAIN_AT && expected_averages.size() != 0) begin
        push <= 1'b0;
      end else if (!(accepted_count >= SEND_QUIET_LO && accepted_count < SEND_QUIET_HI)
                   && $urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
      end else begin
        push    <= 1'b1;
        pixel_i <= pixel_backlog[0];
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected transaction: gray_avg %0d frame_last %0d",
                 result_o.gray_avg, result_o.frame_last);
          fail_count++;
        end else begin
          if (result_o.gray_avg !== expected_averages[0].gray_avg) begin
            $error("gray_avg mismatch: expected %0d actual %0d",
                   expected_averages[0].gray_avg, result_o.gray_avg);
            fail_count++;
          end
          if (result_o.frame_last !== expected_averages[0].frame_last) begin
            $error("frame_last mismatch: expected %0d actual %0d",
                   expected_averages[0].frame_last, result_o.frame_last);
            fail_count++;
          end
          void'(expected_averages.pop_front());
        end
        received_count++;
        if (result_o.frame_last) frame_ends++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held_off && received_count == HOLD_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (received_count >= RECV_QUIET_LO && received_count < RECV_QUIET_HI) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    pixel_t px;
    pixel_t prev;
    int     mode;
    left_gray = '0;
    col_pos   = 0;
    row_pos   = 0;
    prev      = '0;
    foreach (pair_line[i]) pair_line[i] = '0;
    foreach (DIRECTED[i]) pixel_backlog.push_back(pixel_t'(DIRECTED[i]));
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      mode = $urandom_range(9);
      if (mode < 6) begin
        px = pixel_t'(24'($urandom_range(24'hFFFFFF)));
      end else if (mode < 8) begin
        px.red   = {8{$urandom_range(1) == 1}};
        px.green = {8{$urandom_range(1) == 1}};
        px.blue  = {8{$urandom_range(1) == 1}};
      end else begin
        px.red   = prev.red + 8'($urandom_range(6)) - 8'd3;
        px.green = prev.green + 8'($urandom_range(6)) - 8'd3;
        px.blue  = prev.blue + 8'($urandom_range(6)) - 8'd3;
      end
      pixel_backlog.push_back(px);
      prev = px;
    end
    total_pixels = pixel_backlog.size();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_count != total_pixels) @(posedge clk_i);
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Streamed %0d pixels (%0d frames of %0dx%0d), checked %0d averages",
             accepted_count, accepted_count / (IMAGE_WIDTH * IMAGE_HEIGHT),
             IMAGE_WIDTH, IMAGE_HEIGHT, received_count);
    $display("Saw %0d frame ends; input held off by full for %0d cycles",
             frame_ends, full_stalls);
    if (fail_count == 0) begin
      $display("rgb_gray_downscale_2x2_unit test passed");
    end else begin
      $display("rgb_gray_downscale_2x2_unit test failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("rgb_gray_downscale_2x2_unit test failed");
    $finish;
  end

endmodule
